@@ rtl/sha256_pkg.sv @@
package sha256_pkg;

	typedef logic [31:0] word_t;
	typedef logic [7:0][31:0] chain_t;

	typedef struct packed {
		logic       start;
		logic       init_chain;
		logic       win_we;
		logic [3:0] win_addr;
		word_t      win_data;
	} core_cmd_t;

	localparam chain_t IV_INIT = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	localparam word_t PAD_WORD = 32'h8000_0000;

	function automatic word_t big_sigma0(input word_t x);
		big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic word_t small_sigma0(input word_t x);
		small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic word_t small_sigma1(input word_t x);
		small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

	function automatic word_t round_k(input logic [5:0] t);
		case (t)
			6'd0:  round_k = 32'h428a2f98;
			6'd1:  round_k = 32'h71374491;
			6'd2:  round_k = 32'hb5c0fbcf;
			6'd3:  round_k = 32'he9b5dba5;
			6'd4:  round_k = 32'h3956c25b;
			6'd5:  round_k = 32'h59f111f1;
			6'd6:  round_k = 32'h923f82a4;
			6'd7:  round_k = 32'hab1c5ed5;
			6'd8:  round_k = 32'hd807aa98;
			6'd9:  round_k = 32'h12835b01;
			6'd10: round_k = 32'h243185be;
			6'd11: round_k = 32'h550c7dc3;
			6'd12: round_k = 32'h72be5d74;
			6'd13: round_k = 32'h80deb1fe;
			6'd14: round_k = 32'h9bdc06a7;
			6'd15: round_k = 32'hc19bf174;
			6'd16: round_k = 32'he49b69c1;
			6'd17: round_k = 32'hefbe4786;
			6'd18: round_k = 32'h0fc19dc6;
			6'd19: round_k = 32'h240ca1cc;
			6'd20: round_k = 32'h2de92c6f;
			6'd21: round_k = 32'h4a7484aa;
			6'd22: round_k = 32'h5cb0a9dc;
			6'd23: round_k = 32'h76f988da;
			6'd24: round_k = 32'h983e5152;
			6'd25: round_k = 32'ha831c66d;
			6'd26: round_k = 32'hb00327c8;
			6'd27: round_k = 32'hbf597fc7;
			6'd28: round_k = 32'hc6e00bf3;
			6'd29: round_k = 32'hd5a79147;
			6'd30: round_k = 32'h06ca6351;
			6'd31: round_k = 32'h14292967;
			6'd32: round_k = 32'h27b70a85;
			6'd33: round_k = 32'h2e1b2138;
			6'd34: round_k = 32'h4d2c6dfc;
			6'd35: round_k = 32'h53380d13;
			6'd36: round_k = 32'h650a7354;
			6'd37: round_k = 32'h766a0abb;
			6'd38: round_k = 32'h81c2c92e;
			6'd39: round_k = 32'h92722c85;
			6'd40: round_k = 32'ha2bfe8a1;
			6'd41: round_k = 32'ha81a664b;
			6'd42: round_k = 32'hc24b8b70;
			6'd43: round_k = 32'hc76c51a3;
			6'd44: round_k = 32'hd192e819;
			6'd45: round_k = 32'hd6990624;
			6'd46: round_k = 32'hf40e3585;
			6'd47: round_k = 32'h106aa070;
			6'd48: round_k = 32'h19a4c116;
			6'd49: round_k = 32'h1e376c08;
			6'd50: round_k = 32'h2748774c;
			6'd51: round_k = 32'h34b0bcb5;
			6'd52: round_k = 32'h391c0cb3;
			6'd53: round_k = 32'h4ed8aa4a;
			6'd54: round_k = 32'h5b9cca4f;
			6'd55: round_k = 32'h682e6ff3;
			6'd56: round_k = 32'h748f82ee;
			6'd57: round_k = 32'h78a5636f;
			6'd58: round_k = 32'h84c87814;
			6'd59: round_k = 32'h8cc70208;
			6'd60: round_k = 32'h90befffa;
			6'd61: round_k = 32'ha4506ceb;
			6'd62: round_k = 32'hbef9a3f7;
			6'd63: round_k = 32'hc67178f2;
			default: round_k = '0;
		endcase
	endfunction

endpackage

@@ rtl/sha256_core.sv @@
module sha256_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sha256_pkg::core_cmd_t cmd,
	output logic                  busy,
	output sha256_pkg::chain_t    chain
);

	sha256_pkg::chain_t chain_q;
	sha256_pkg::word_t  wv_q [8];
	sha256_pkg::word_t  win_q [16];
	logic [5:0]         rnd_q;
	logic               busy_q;
	logic               add_q;

	sha256_pkg::word_t w_cur;
	sha256_pkg::word_t t1;
	sha256_pkg::word_t t2;
	logic              rounding;

	assign rounding = busy_q && !add_q;

	always_comb begin
		if (rnd_q[5:4] == 2'b00) begin
			w_cur = win_q[0];
		end else begin
			w_cur = sha256_pkg::small_sigma1(win_q[14]) + win_q[9]
			      + sha256_pkg::small_sigma0(win_q[1]) + win_q[0];
		end
		t1 = wv_q[7] + sha256_pkg::big_sigma1(wv_q[4])
		   + ((wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]))
		   + sha256_pkg::round_k(rnd_q) + w_cur;
		t2 = sha256_pkg::big_sigma0(wv_q[0])
		   + ((wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= sha256_pkg::IV_INIT;
			busy_q  <= 1'b0;
			add_q   <= 1'b0;
			rnd_q   <= '0;
		end else begin
			if (cmd.init_chain) begin
				chain_q <= sha256_pkg::IV_INIT;
			end
			if (cmd.start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (rounding) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'd63) begin
					add_q <= 1'b1;
				end
			end else if (add_q) begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= chain_q[i] + wv_q[i];
				end
				add_q  <= 1'b0;
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			for (int i = 0; i < 8; i++) begin
				wv_q[i] <= chain_q[i];
			end
		end else if (rounding) begin
			wv_q[7] <= wv_q[6];
			wv_q[6] <= wv_q[5];
			wv_q[5] <= wv_q[4];
			wv_q[4] <= wv_q[3] + t1;
			wv_q[3] <= wv_q[2];
			wv_q[2] <= wv_q[1];
			wv_q[1] <= wv_q[0];
			wv_q[0] <= t1 + t2;
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[15] <= w_cur;
		end
		if (cmd.win_we) begin
			win_q[cmd.win_addr] <= cmd.win_data;
		end
	end

	assign busy  = busy_q;
	assign chain = chain_q;

endmodule

@@ rtl/sha256_stream_hasher.sv @@
// Streaming SHA-256 hasher. Message words arrive big-endian with a count of valid leading
// bytes. A word that closes a 64-byte block starts the shared round unit, which runs one
// round per cycle and then adds into the chaining value; in_ready is low while it is busy.
// The final word starts the padding sequence: the pad byte, zero bytes up to the length
// field, the high and low length words, and one or two compressions. In double mode the
// first digest is copied back into the message window, padded and compressed once more.
// The eight digest words then leave one per accepted cycle, and the block is ready for the
// next message. The double_hash setting is sampled on the final word.
module sha256_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        double_hash,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] data_word,
	input  logic [2:0]  byte_count,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        digest_end
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PAD80 = 3'd1;
	localparam logic [2:0] ST_PADZ  = 3'd2;
	localparam logic [2:0] ST_LENHI = 3'd3;
	localparam logic [2:0] ST_LENLO = 3'd4;
	localparam logic [2:0] ST_COPY  = 3'd5;
	localparam logic [2:0] ST_OUT   = 3'd6;

	localparam logic [5:0] LEN_FILL = 6'd56;

	logic [2:0]  state_q;
	logic [5:0]  fill_q;
	logic [63:0] bit_len_q;
	logic [31:0] part_q;
	logic        dbl_cfg_q;
	logic        dbl_q;
	logic        second_q;
	logic [2:0]  idx_q;

	sha256_pkg::core_cmd_t cmd;
	sha256_pkg::chain_t    chain;
	logic                  core_busy;

	logic        ins_en;
	logic        ins_len;
	logic [31:0] ins_data;
	logic [2:0]  ins_cnt;
	logic [2:0]  in_cnt;
	logic [1:0]  offs;
	logic [3:0]  span;
	logic [6:0]  fill_next;
	logic [31:0] keep_mask;
	logic [31:0] data_mask;
	logic [63:0] pair;
	logic        act;
	logic        in_acc;
	logic        out_acc;

	sha256_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.busy   (core_busy),
		.chain  (chain)
	);

	assign act     = !core_busy;
	assign in_ready  = (state_q == ST_IDLE) && act;
	assign out_valid = (state_q == ST_OUT) && act;
	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;
	assign cfg_ready = 1'b1;

	assign in_cnt = (byte_count > 3'd4) ? 3'd4 : byte_count;

	always_comb begin
		ins_en   = 1'b0;
		ins_len  = 1'b0;
		ins_data = '0;
		ins_cnt  = 3'd0;
		case (state_q)
			ST_IDLE: begin
				ins_en   = in_acc;
				ins_len  = 1'b1;
				ins_data = data_word;
				ins_cnt  = in_cnt;
			end
			ST_PAD80: begin
				ins_en   = act;
				ins_data = sha256_pkg::PAD_WORD;
				ins_cnt  = 3'd1;
			end
			ST_PADZ: begin
				ins_en  = act && (fill_q != LEN_FILL);
				ins_cnt = 3'd4 - {1'b0, fill_q[1:0]};
			end
			ST_LENHI: begin
				ins_en   = act;
				ins_data = bit_len_q[63:32];
				ins_cnt  = 3'd4;
			end
			ST_LENLO: begin
				ins_en   = act;
				ins_data = bit_len_q[31:0];
				ins_cnt  = 3'd4;
			end
			default: begin
				ins_en = 1'b0;
			end
		endcase
	end

	always_comb begin
		offs      = fill_q[1:0];
		span      = {2'b00, offs} + {1'b0, ins_cnt};
		fill_next = {1'b0, fill_q} + {4'b0000, ins_cnt};
		keep_mask = ~(32'hffff_ffff >> {offs, 3'b000});
		data_mask = ~(32'hffff_ffff >> {ins_cnt, 3'b000});
		pair      = {part_q & keep_mask, 32'h0}
		          | ({ins_data & data_mask, 32'h0} >> {offs, 3'b000});
	end

	always_comb begin
		cmd = '0;
		if (ins_en) begin
			cmd.win_we   = span >= 4'd4;
			cmd.win_addr = fill_q[5:2];
			cmd.win_data = pair[63:32];
			cmd.start    = fill_next[6];
		end else if ((state_q == ST_COPY) && act) begin
			cmd.win_we     = 1'b1;
			cmd.win_addr   = {1'b0, idx_q};
			cmd.win_data   = chain[idx_q];
			cmd.init_chain = idx_q == 3'd7;
		end else if (out_acc) begin
			cmd.init_chain = idx_q == 3'd7;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fill_q    <= '0;
			bit_len_q <= '0;
			dbl_cfg_q <= 1'b0;
			dbl_q     <= 1'b0;
			second_q  <= 1'b0;
			idx_q     <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				dbl_cfg_q <= double_hash;
			end
			if (ins_en) begin
				fill_q <= fill_next[5:0];
				if (ins_len) begin
					bit_len_q <= bit_len_q + {58'b0, ins_cnt, 3'b000};
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && end_of_message) begin
						dbl_q   <= dbl_cfg_q;
						state_q <= ST_PAD80;
					end
				end
				ST_PAD80: begin
					if (act) begin
						state_q <= ST_PADZ;
					end
				end
				ST_PADZ: begin
					if (act && (fill_q == LEN_FILL)) begin
						state_q <= ST_LENHI;
					end
				end
				ST_LENHI: begin
					if (act) begin
						state_q <= ST_LENLO;
					end
				end
				ST_LENLO: begin
					if (act) begin
						idx_q <= '0;
						if (dbl_q && !second_q) begin
							state_q <= ST_COPY;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_COPY: begin
					if (act) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							fill_q    <= 6'd32;
							bit_len_q <= 64'd256;
							second_q  <= 1'b1;
							state_q   <= ST_PAD80;
						end
					end
				end
				ST_OUT: begin
					if (out_acc) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							fill_q    <= '0;
							bit_len_q <= '0;
							second_q  <= 1'b0;
							state_q   <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ins_en) begin
			if (span >= 4'd4) begin
				part_q <= pair[31:0];
			end else begin
				part_q <= pair[63:32];
			end
		end
	end

	assign digest_word = chain[idx_q];
	assign word_index  = idx_q;
	assign digest_end  = idx_q == 3'd7;

	// Input and output sides are never open at the same time.
	assert property (@(posedge clk) disable iff (!arst_n) !(in_ready && out_valid))
		else $error("input and output handshakes open together");

	// A new compression is only started on an idle round unit.
	assert property (@(posedge clk) disable iff (!arst_n) cmd.start |-> !core_busy)
		else $error("compression started while round unit busy");

	// Padding always closes a block, so digest words are shown with an empty block buffer.
	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> (fill_q == 6'd0))
		else $error("digest shown with a partly filled block");

	// After the last digest word the block takes input again at once.
	assert property (@(posedge clk) disable iff (!arst_n) (out_acc && digest_end) |=> in_ready)
		else $error("not ready after the last digest word");

endmodule

@@ dv/sha256_stream_hasher_test.sv @@
`timescale 1ns / 1ps

module sha256_stream_hasher_test;

	typedef sha256_pkg::word_t word_t;

	localparam int CYCLE_LIMIT = 400000;

	localparam word_t ROUND_K [0:63] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam word_t START_HASH [0:7] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef struct packed {
		word_t      data;
		logic [2:0] count;
		logic       eom;
	} msg_word_t;

	typedef struct packed {
		word_t      word;
		logic [2:0] index;
		logic       last;
	} digest_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        double_hash = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] data_word = '0;
	logic [2:0]  byte_count = '0;
	logic        end_of_message = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        digest_end;

	msg_word_t pending_words [$];
	digest_t   digest_q [$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int errors = 0;
	int cycles = 0;

	word_t      chain [0:7];
	logic [7:0] blk_bytes [0:63];
	logic [5:0] blk_fill;
	logic [63:0] bit_count;
	logic       dbl_mode;

	sha256_stream_hasher uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.double_hash    (double_hash),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_word      (data_word),
		.byte_count     (byte_count),
		.end_of_message (end_of_message),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.digest_word    (digest_word),
		.word_index     (word_index),
		.digest_end     (digest_end)
	);

	function automatic word_t rotr(word_t x, int unsigned s);
		return (x >> s) | (x << (32 - s));
	endfunction

	task automatic compress_block();
		word_t w [0:63];
		word_t va, vb, vc, vd, ve, vf, vg, vh, t1, t2;
		for (int t = 0; t < 16; t++)
			w[t] = {blk_bytes[4*t], blk_bytes[4*t+1], blk_bytes[4*t+2], blk_bytes[4*t+3]};
		for (int t = 16; t < 64; t++)
			w[t] = (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
				+ (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
		va = chain[0]; vb = chain[1]; vc = chain[2]; vd = chain[3];
		ve = chain[4]; vf = chain[5]; vg = chain[6]; vh = chain[7];
		for (int t = 0; t < 64; t++) begin
			t1 = vh + (rotr(ve, 6) ^ rotr(ve, 11) ^ rotr(ve, 25)) + ((ve & vf) ^ (~ve & vg))
				+ ROUND_K[t] + w[t];
			t2 = (rotr(va, 2) ^ rotr(va, 13) ^ rotr(va, 22)) + ((va & vb) ^ (va & vc) ^ (vb & vc));
			vh = vg; vg = vf; vf = ve; ve = vd + t1;
			vd = vc; vc = vb; vb = va; va = t1 + t2;
		end
		chain[0] += va; chain[1] += vb; chain[2] += vc; chain[3] += vd;
		chain[4] += ve; chain[5] += vf; chain[6] += vg; chain[7] += vh;
	endtask

	task automatic put_byte(input logic [7:0] b);
		blk_bytes[blk_fill] = b;
		blk_fill = blk_fill + 6'd1;
		if (blk_fill == 6'd0)
			compress_block();
	endtask

	task automatic restart_hash();
		chain = START_HASH;
		bit_count = '0;
		blk_fill = '0;
	endtask

	task automatic close_message();
		logic [63:0] len;
		len = bit_count;
		put_byte(8'h80);
		while (blk_fill != 6'd56)
			put_byte(8'h00);
		for (int i = 7; i >= 0; i--)
			put_byte(len[8*i +: 8]);
	endtask

	task automatic hash_word(input word_t data, input logic [2:0] count, input logic eom);
		int n;
		word_t first [0:7];
		digest_t d;
		n = (count > 3'd4) ? 4 : int'(count);
		for (int i = 0; i < n; i++) begin
			bit_count += 64'd8;
			put_byte(data[31-8*i -: 8]);
		end
		if (eom) begin
			close_message();
			if (dbl_mode) begin
				first = chain;
				restart_hash();
				for (int i = 0; i < 32; i++) begin
					bit_count += 64'd8;
					put_byte(first[i/4][31-8*(i%4) -: 8]);
				end
				close_message();
			end
			for (int i = 0; i < 8; i++) begin
				d.word = chain[i];
				d.index = 3'(i);
				d.last = (i == 7);
				digest_q = {digest_q, d};
			end
			restart_hash();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : drive
		msg_word_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				hash_word(data_word, byte_count, end_of_message);
			if (!in_valid || in_ready) begin
				if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pending_words.pop_front();
					in_valid <= 1'b1;
					data_word <= nxt.data;
					byte_count <= nxt.count;
					end_of_message <= nxt.eom;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : watch
		digest_t exp_d;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (digest_q.size() == 0) begin
					$error("unexpected digest word %h", digest_word);
					errors++;
				end else begin
					exp_d = digest_q.pop_front();
					if (digest_word !== exp_d.word) begin
						$error("digest_word: expected %h, got %h", exp_d.word, digest_word);
						errors++;
					end
					if (word_index !== exp_d.index) begin
						$error("word_index: expected %0d, got %0d", exp_d.index, word_index);
						errors++;
					end
					if (digest_end !== exp_d.last) begin
						$error("digest_end: expected %0b, got %0b", exp_d.last, digest_end);
						errors++;
					end
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		forever #4 clk = ~clk;
	end

	task automatic add_word(input word_t data, input logic [2:0] count, input logic eom);
		msg_word_t m;
		m.data = data;
		m.count = count;
		m.eom = eom;
		pending_words = {pending_words, m};
	endtask

	function automatic word_t rand_data();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic add_message(input int nwords);
		int r;
		for (int i = 0; i < nwords - 1; i++) begin
			r = $urandom_range(9);
			if (r == 6)
				add_word(rand_data(), 3'($urandom_range(3)), 1'b0);
			else if (r == 7)
				add_word(rand_data(), 3'($urandom_range(7, 5)), 1'b0);
			else
				add_word(rand_data(), 3'd4, 1'b0);
		end
		add_word(rand_data(), 3'($urandom_range(7)), 1'b1);
	endtask

	task automatic set_double_mode(input logic v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		double_hash <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		dbl_mode = v;
	endtask

	task automatic wait_drained();
		do @(negedge clk); while (pending_words.size() != 0 || in_valid || digest_q.size() != 0);
	endtask

	initial begin
		int added;
		dbl_mode = 1'b0;
		restart_hash();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		set_double_mode(1'b0);
		@(negedge clk);
		add_word(32'h0000_0000, 3'd0, 1'b1);
		add_word(32'h6162_63ff, 3'd3, 1'b1);
		add_word(32'hffff_ffff, 3'd4, 1'b1);
		add_word(32'h0000_0000, 3'd4, 1'b1);
		add_word(32'h1234_5678, 3'd7, 1'b1);
		add_word(32'h89ab_cdef, 3'd5, 1'b0);
		add_word(32'hfedc_ba98, 3'd6, 1'b1);
		add_word(32'ha1b2_c3d4, 3'd1, 1'b0);
		add_word(32'h5566_7788, 3'd2, 1'b0);
		add_word(32'hffff_ffff, 3'd0, 1'b0);
		add_word(32'h0f1e_2d3c, 3'd3, 1'b1);
		// Fifty-six bytes leave no room for the length, so padding takes a second block.
		for (int i = 0; i < 13; i++)
			add_word($urandom, 3'd4, 1'b0);
		add_word($urandom, 3'd4, 1'b1);
		wait_drained();

		for (int phase = 0; phase < 8; phase++) begin
			repeat (20) @(posedge clk);
			set_double_mode(phase[0]);
			@(negedge clk);
			send_idle_pct = (phase / 2 == 1) ? 68 : (phase / 2 == 3) ? 32 : 0;
			recv_stall_pct = (phase / 2 == 2) ? 68 : (phase / 2 == 3) ? 32 : 0;
			added = 0;
			while (added < 11) begin
				if ($urandom_range(3) == 0) begin
					add_message($urandom_range(18, 12));
				end else begin
					add_message($urandom_range(6, 1));
				end
				added = pending_words.size();
			end
			wait_drained();
		end

		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
